// ===== hdl/minimum_covering_window_unit_defines.svh =====
// Assertion macros used by the checker of the minimum covering window unit.
`ifndef MINIMUM_COVERING_WINDOW_UNIT_DEFINES_SVH
`define MINIMUM_COVERING_WINDOW_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mcw_pkg.sv =====
// Constants and action codes of the minimum covering window unit.
`timescale 1ns / 1ps
package mcw_pkg;

    localparam int MAX_TEXT    = 1024;
    localparam int MAX_PATTERN = 1024;
    localparam int ALPHABET    = 26;

    localparam int LETTER_W  = 5;
    localparam int ACTION_W  = 2;
    localparam int ADDR_W    = $clog2(MAX_TEXT);
    localparam int POS_W     = $clog2(MAX_TEXT + 1);
    localparam int IDX_W     = $clog2(ALPHABET);
    localparam int CNT_MAX   = (MAX_TEXT > MAX_PATTERN) ? MAX_TEXT : MAX_PATTERN;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int PTOT_W    = $clog2(MAX_PATTERN + 1);

    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PATTERN = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TEXT    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FINISH  = 2'd3;

endpackage

// ===== hdl/minimum_covering_window_unit.sv =====
// Top level of the minimum covering window unit: job state, text buffer and sequencer.
//
// The unit finds the shortest stretch of the buffered text that holds every
// pattern letter at least as often as the pattern does, keeping the earliest
// one on ties. Clear, pattern and finish transactions are done in the idle
// state. A text transaction records the letter in the idle state; then the
// sequencer alternates between a check state, which tests whether the window
// still covers the pattern and records a shorter window, and a drop state,
// which removes the leftmost letter: its read of the text buffer is registered
// in the check state and the counter update follows in the drop state. A text
// letter outside the alphabet, a letter that finds the buffer full and any text
// letter while the pattern is empty are done in the idle state.
// Coverage is tracked by a running count of missing pattern letters, so no
// scan over the alphabet is ever needed. Every transaction waits while an
// earlier report is still stalled at the output.
`timescale 1ns / 1ps
module minimum_covering_window_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mcw_pkg::ACTION_W-1:0]  action,
    input  logic [mcw_pkg::LETTER_W-1:0]  letter,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [mcw_pkg::ADDR_W-1:0]    window_start,
    output logic [mcw_pkg::POS_W-1:0]     window_length,
    output logic                          overflowed
);
    import mcw_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  pattern_counts_reg [ALPHABET];
    logic [CNT_W-1:0]  window_counts_reg [ALPHABET];
    logic [IDX_W-1:0]  text_mem [MAX_TEXT];
    logic [IDX_W-1:0]  rd_data_reg;

    logic [POS_W-1:0]  low_reg, low_next;
    logic [POS_W-1:0]  high_reg, high_next;
    logic [POS_W-1:0]  best_len_reg, best_len_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;
    logic              have_best_reg, have_best_next;
    logic              overflow_reg, overflow_next;
    logic [PTOT_W-1:0] ptotal_reg, ptotal_next;
    logic [CNT_W-1:0]  need_reg, need_next;

    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [POS_W-1:0]  length_reg, length_next;
    logic              oflow_out_reg, oflow_out_next;

    logic              accept;
    logic              letter_ok;
    logic              clr;
    logic              pat_inc;
    logic              win_inc;
    logic              win_dec;
    logic              mem_we;
    logic [IDX_W-1:0]  cur_idx;
    logic [CNT_W-1:0]  pat_cnt;
    logic [CNT_W-1:0]  win_cnt;
    logic [POS_W-1:0]  span;

    assign in_stall      = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept        = in_valid && !in_stall;
    assign letter_ok     = {1'b0, letter} < (LETTER_W + 1)'(ALPHABET);
    assign cur_idx       = (state_reg == ST_DROP) ? rd_data_reg : letter[IDX_W-1:0];
    assign pat_cnt       = pattern_counts_reg[cur_idx];
    assign win_cnt       = window_counts_reg[cur_idx];
    assign span          = high_reg - low_reg;

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign window_start  = start_reg;
    assign window_length = length_reg;
    assign overflowed    = oflow_out_reg;

    always_comb
    begin
        state_next      = state_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        have_best_next  = have_best_reg;
        overflow_next   = overflow_reg;
        ptotal_next     = ptotal_reg;
        need_next       = need_reg;
        clr             = 1'b0;
        pat_inc         = 1'b0;
        win_inc         = 1'b0;
        win_dec         = 1'b0;
        mem_we          = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        found_next      = found_reg;
        start_next      = start_reg;
        length_next     = length_reg;
        oflow_out_next  = oflow_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_CLEAR:
                        begin
                            clr             = 1'b1;
                            low_next        = '0;
                            high_next       = '0;
                            best_len_next   = '0;
                            best_start_next = '0;
                            have_best_next  = 1'b0;
                            overflow_next   = 1'b0;
                            ptotal_next     = '0;
                            need_next       = '0;
                        end
                        ACT_PATTERN:
                        begin
                            if (letter_ok && high_reg == '0)
                            begin
                                if (ptotal_reg >= PTOT_W'(MAX_PATTERN))
                                begin
                                    overflow_next = 1'b1;
                                end
                                else
                                begin
                                    pat_inc     = 1'b1;
                                    ptotal_next = ptotal_reg + 1'b1;
                                    need_next   = need_reg + 1'b1;
                                end
                            end
                        end
                        ACT_TEXT:
                        begin
                            if (letter_ok)
                            begin
                                if (high_reg >= POS_W'(MAX_TEXT))
                                begin
                                    overflow_next = 1'b1;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    win_inc   = 1'b1;
                                    high_next = high_reg + 1'b1;
                                    if (win_cnt < pat_cnt)
                                    begin
                                        need_next = need_reg - 1'b1;
                                    end
                                    if (ptotal_reg == '0)
                                    begin
                                        have_best_next  = 1'b1;
                                        best_start_next = '0;
                                        best_len_next   = '0;
                                    end
                                    else
                                    begin
                                        state_next = ST_CHECK;
                                    end
                                end
                            end
                        end
                        ACT_FINISH:
                        begin
                            out_valid_next = 1'b1;
                            found_next     = have_best_reg;
                            start_next     = have_best_reg ? best_start_reg : '0;
                            length_next    = have_best_reg ? best_len_reg : '0;
                            oflow_out_next = overflow_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (low_reg < high_reg && need_reg == '0)
                begin
                    if (!have_best_reg || best_len_reg > span)
                    begin
                        have_best_next  = 1'b1;
                        best_len_next   = span;
                        best_start_next = low_reg[ADDR_W-1:0];
                    end
                    state_next = ST_DROP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DROP:
            begin
                win_dec  = 1'b1;
                low_next = low_reg + 1'b1;
                if (win_cnt <= pat_cnt)
                begin
                    need_next = need_reg + 1'b1;
                end
                state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_reg        <= '0;
            high_reg       <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
            have_best_reg  <= 1'b0;
            overflow_reg   <= 1'b0;
            ptotal_reg     <= '0;
            need_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
            have_best_reg  <= have_best_next;
            overflow_reg   <= overflow_next;
            ptotal_reg     <= ptotal_next;
            need_reg       <= need_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg     <= found_next;
        start_reg     <= start_next;
        length_reg    <= length_next;
        oflow_out_reg <= oflow_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                pattern_counts_reg[i] <= '0;
                window_counts_reg[i]  <= '0;
            end
        end
        else if (clr)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                pattern_counts_reg[i] <= '0;
                window_counts_reg[i]  <= '0;
            end
        end
        else
        begin
            if (pat_inc)
            begin
                pattern_counts_reg[cur_idx] <= pat_cnt + 1'b1;
            end
            if (win_inc)
            begin
                window_counts_reg[cur_idx] <= win_cnt + 1'b1;
            end
            else if (win_dec)
            begin
                window_counts_reg[cur_idx] <= win_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_mem[high_reg[ADDR_W-1:0]] <= letter[IDX_W-1:0];
        end
        rd_data_reg <= text_mem[low_reg[ADDR_W-1:0]];
    end

endmodule

// ===== hdl/mcw_checker.sv =====
// Port-level checker of the minimum covering window unit and its bind statement.
`timescale 1ns / 1ps
`include "minimum_covering_window_unit_defines.svh"
module mcw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [mcw_pkg::ACTION_W-1:0]  action,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          found,
    input logic [mcw_pkg::ADDR_W-1:0]    window_start,
    input logic [mcw_pkg::POS_W-1:0]     window_length,
    input logic                          overflowed
);
    import mcw_pkg::*;

    logic in_accept;
    logic [POS_W:0] window_end;

    assign in_accept  = in_valid && !in_stall;
    assign window_end = (POS_W + 1)'(window_start) + (POS_W + 1)'(window_length);

    `MCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(found) && $stable(window_start)
        && $stable(window_length) && $stable(overflowed),
        "Stalled report changed before it was taken.")
    `MCW_ASSERT_NOW(a_none_zero, clk, rst_n, out_valid && !found,
        window_start == '0 && window_length == '0,
        "Report without a window carries a nonzero start or length.")
    `MCW_ASSERT_NOW(a_window_in_text, clk, rst_n, out_valid && found,
        window_end <= (POS_W + 1)'(MAX_TEXT),
        "Reported window reaches past the text buffer.")
    `MCW_ASSERT_NEXT(a_no_spurious_report, clk, rst_n,
        !out_valid && !(in_accept && action == ACT_FINISH),
        !out_valid,
        "Report appeared without a finish transaction.")

endmodule

bind minimum_covering_window_unit mcw_checker u_mcw_checker (.*);

// ===== dv/tb_minimum_covering_window_unit.sv =====
// Self-checking testbench of the minimum covering window unit with a built-in window predictor.
`timescale 1ns / 1ps

import mcw_pkg::*;

typedef struct {
    logic              found;
    logic [ADDR_W-1:0] start;
    logic [POS_W-1:0]  length;
    logic              ovf;
} window_report_t;

class window_scoreboard;
    int unsigned    pattern_cnt[ALPHABET];
    int unsigned    window_cnt[ALPHABET];
    logic [LETTER_W-1:0] text_buf[MAX_TEXT];
    int unsigned    low;
    int unsigned    high;
    int unsigned    best_len;
    int unsigned    best_start;
    bit             have_best;
    bit             overflow_seen;
    int unsigned    pattern_total;
    window_report_t pending_reports[$];
    int             errors;

    function new();
        errors = 0;
        clear_job();
    endfunction

    function void clear_job();
        foreach (pattern_cnt[i])
        begin
            pattern_cnt[i] = 0;
            window_cnt[i] = 0;
        end
        low = 0;
        high = 0;
        best_len = 0;
        best_start = 0;
        have_best = 0;
        overflow_seen = 0;
        pattern_total = 0;
    endfunction

    function bit window_covers();
        foreach (pattern_cnt[i])
        begin
            if (window_cnt[i] < pattern_cnt[i])
                return 0;
        end
        return 1;
    endfunction

    function void add_text(logic [LETTER_W-1:0] ltr);
        logic [LETTER_W-1:0] old;
        if (high >= MAX_TEXT)
        begin
            overflow_seen = 1;
            return;
        end
        text_buf[high] = ltr;
        window_cnt[ltr]++;
        high++;
        if (pattern_total == 0)
        begin
            have_best = 1;
            best_start = 0;
            best_len = 0;
            return;
        end
        while (low < high && window_covers())
        begin
            if (!have_best || best_len > high - low)
            begin
                have_best = 1;
                best_len = high - low;
                best_start = low;
            end
            old = text_buf[low];
            if (window_cnt[old] > 0)
                window_cnt[old]--;
            low++;
        end
    endfunction

    function void note_transaction(logic [ACTION_W-1:0] act, logic [LETTER_W-1:0] ltr);
        window_report_t rep;
        case (act)
            ACT_CLEAR:
                clear_job();
            ACT_PATTERN:
            begin
                if (ltr < ALPHABET && high == 0)
                begin
                    if (pattern_total >= MAX_PATTERN)
                        overflow_seen = 1;
                    else
                    begin
                        pattern_cnt[ltr]++;
                        pattern_total++;
                    end
                end
            end
            ACT_TEXT:
            begin
                if (ltr < ALPHABET)
                    add_text(ltr);
            end
            default:
            begin
                rep.found = have_best;
                rep.start = have_best ? best_start[ADDR_W-1:0] : '0;
                rep.length = have_best ? best_len[POS_W-1:0] : '0;
                rep.ovf = overflow_seen;
                pending_reports.push_back(rep);
            end
        endcase
    endfunction

    function void check_report(logic fnd, logic [ADDR_W-1:0] st, logic [POS_W-1:0] len,
                               logic ovf);
        window_report_t exp_rep;
        if (pending_reports.size() == 0)
        begin
            $error("unexpected report: found=%0d window_start=%0d window_length=%0d",
                   fnd, st, len);
            errors++;
            return;
        end
        exp_rep = pending_reports.pop_front();
        if (fnd !== exp_rep.found)
        begin
            $error("found: expected %0d, actual %0d", exp_rep.found, fnd);
            errors++;
        end
        if (st !== exp_rep.start)
        begin
            $error("window_start: expected %0d, actual %0d", exp_rep.start, st);
            errors++;
        end
        if (len !== exp_rep.length)
        begin
            $error("window_length: expected %0d, actual %0d", exp_rep.length, len);
            errors++;
        end
        if (ovf !== exp_rep.ovf)
        begin
            $error("overflowed: expected %0d, actual %0d", exp_rep.ovf, ovf);
            errors++;
        end
    endfunction
endclass

module tb_minimum_covering_window_unit;

    localparam int IDLE_LIMIT  = 10000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_ITEMS  = 800;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action = ACT_CLEAR;
    logic [LETTER_W-1:0] letter = '0;
    logic                out_valid;
    logic                out_stall = 1'b1;
    logic                found;
    logic [ADDR_W-1:0]   window_start;
    logic [POS_W-1:0]    window_length;
    logic                overflowed;

    window_scoreboard board = new();
    bit burst_mode = 0;
    bit hold_pending = 0;
    int idle_cycles = 0;
    int items_sent = 0;

    minimum_covering_window_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .letter        (letter),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .window_start  (window_start),
        .window_length (window_length),
        .overflowed    (overflowed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [LETTER_W-1:0] ltr);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        letter <= ltr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_transaction(act, ltr);
        items_sent++;
    endtask

    function automatic logic [LETTER_W-1:0] pick_letter(int base, int span);
        if ($urandom_range(0, 15) == 0)
            return LETTER_W'($urandom_range(ALPHABET, 31));
        return LETTER_W'(base + $urandom_range(0, span - 1));
    endfunction

    task automatic run_random_job();
        int span;
        int base;
        int plen;
        int tlen;
        int r;
        span = ($urandom_range(0, 3) == 0) ? ALPHABET : $urandom_range(2, 5);
        base = $urandom_range(0, ALPHABET - span);
        burst_mode = ($urandom_range(0, 3) == 0);
        send_item(ACT_CLEAR, LETTER_W'($urandom_range(0, 31)));
        plen = $urandom_range(0, 5);
        repeat (plen)
            send_item(ACT_PATTERN, pick_letter(base, span));
        tlen = $urandom_range(1, 40);
        repeat (tlen)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_item(ACT_FINISH, LETTER_W'($urandom_range(0, 31)));
            else if (r == 1)
                send_item(ACTION_W'($urandom_range(1, 3)), LETTER_W'($urandom_range(0, 31)));
            else if (r == 2)
                send_item(ACT_PATTERN, pick_letter(base, span));
            else
                send_item(ACT_TEXT, pick_letter(base, span));
        end
        send_item(ACT_FINISH, LETTER_W'($urandom_range(0, 31)));
    endtask

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 0;
                gap = LONG_HOLD;
            end
            else
                gap = burst_mode ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            board.check_report(found, window_start, window_length, overflowed);
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ACT_FINISH, '0);
        send_item(ACT_PATTERN, 5'd0);
        send_item(ACT_PATTERN, 5'd25);
        send_item(ACT_PATTERN, 5'd26);
        send_item(ACT_PATTERN, 5'd31);
        send_item(ACT_FINISH, '0);
        send_item(ACT_TEXT, 5'd25);
        send_item(ACT_TEXT, 5'd31);
        send_item(ACT_TEXT, 5'd3);
        send_item(ACT_TEXT, 5'd0);
        send_item(ACT_TEXT, 5'd25);
        send_item(ACT_PATTERN, 5'd1);
        send_item(ACT_FINISH, '0);
        send_item(ACT_FINISH, '0);
        send_item(ACT_CLEAR, '0);
        send_item(ACT_TEXT, 5'd7);
        send_item(ACT_FINISH, '0);
        send_item(ACT_CLEAR, 5'd31);
        send_item(ACT_FINISH, 5'd31);
        send_item(ACT_PATTERN, 5'd2);
        send_item(ACT_PATTERN, 5'd2);
        send_item(ACT_TEXT, 5'd2);
        send_item(ACT_TEXT, 5'd4);
        send_item(ACT_TEXT, 5'd2);
        send_item(ACT_FINISH, '0);

        burst_mode = 1;
        hold_pending = 1;
        repeat (8)
            send_item(ACT_FINISH, LETTER_W'($urandom_range(0, 31)));

        items_sent = 0;
        while (items_sent < RAND_ITEMS)
            run_random_job();

        in_valid <= 1'b0;
        while (board.pending_reports.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== minimum_covering_window_unit.f =====
+incdir+hdl
hdl/mcw_pkg.sv
hdl/minimum_covering_window_unit.sv
hdl/mcw_checker.sv
dv/tb_minimum_covering_window_unit.sv
